FILE: hdl/hvg_pkg.sv
package hvg_pkg;

  localparam int COORD_W    = 12;
  localparam int DIM_W      = 13;
  localparam int PITCH_W    = 14;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;
  localparam int OFFSET_W   = 27;
  localparam int COLOR_W    = 8;
  localparam int PROD_W     = COORD_W + PITCH_W;

  localparam int HUE_Q_W    = 9;
  localparam int DIV_STAGES = HUE_Q_W;
  localparam int DIV_W      = 21;

  localparam int FRAC_W      = 6;
  localparam int RAMP_W      = COLOR_W + FRAC_W;
  localparam int RECIP_W     = 15;
  localparam int RECIP_SHIFT = 20;
  localparam logic [RECIP_W-1:0] RECIP_60 = 15'd17477;

  localparam int LATENCY = DIV_STAGES + 3;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_PITCH   = 2'd2;

  localparam logic [DIM_W-1:0]   RST_FRAME_WIDTH  = 13'd640;
  localparam logic [DIM_W-1:0]   RST_FRAME_HEIGHT = 13'd480;
  localparam logic [PITCH_W-1:0] RST_LINE_PITCH   = 14'd640;

  localparam logic [DIV_W-1:0]   HUE_SCALE = 21'd360;
  localparam logic [DIV_W-1:0]   VAL_SCALE = 21'd255;
  localparam logic [COLOR_W-1:0] VAL_MAX   = 8'd255;

  localparam logic [HUE_Q_W-1:0] HUE_60  = 9'd60;
  localparam logic [HUE_Q_W-1:0] HUE_120 = 9'd120;
  localparam logic [HUE_Q_W-1:0] HUE_180 = 9'd180;
  localparam logic [HUE_Q_W-1:0] HUE_240 = 9'd240;
  localparam logic [HUE_Q_W-1:0] HUE_300 = 9'd300;
  localparam logic [HUE_Q_W-1:0] HUE_360 = 9'd360;

  typedef logic [1:0] chan_sel_t;
  localparam chan_sel_t SEL_ZERO = 2'd0;
  localparam chan_sel_t SEL_FULL = 2'd1;
  localparam chan_sel_t SEL_RAMP = 2'd2;

endpackage

FILE: hdl/hue_value_gradient_pixel.sv
// Throughput: one pixel per cycle; busy is always low. The hue and value
// divisions run as a 9-stage restoring divider, one quotient bit per stage,
// followed by a sector stage and a reciprocal-multiply stage.
// Reset (rst, synchronous) clears all in-flight beats and loads 640x480, pitch 640.
module hue_value_gradient_pixel (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [hvg_pkg::COORD_W-1:0]       pixel_x,
  input  logic [hvg_pkg::COORD_W-1:0]       pixel_y,
  input  logic                              cfg_we,
  input  logic [hvg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hvg_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                              done,
  output logic                              in_frame,
  output logic [hvg_pkg::OFFSET_W-1:0]      pixel_offset,
  output logic [hvg_pkg::COLOR_W-1:0]       red,
  output logic [hvg_pkg::COLOR_W-1:0]       green,
  output logic [hvg_pkg::COLOR_W-1:0]       blue
);

  localparam int NS = hvg_pkg::DIV_STAGES;
  localparam int DW = hvg_pkg::DIV_W;

  logic [hvg_pkg::DIM_W-1:0]   frame_width;
  logic [hvg_pkg::DIM_W-1:0]   frame_height;
  logic [hvg_pkg::PITCH_W-1:0] line_pitch;

  logic                           accept;
  logic [hvg_pkg::PROD_W-1:0]     s1_prod;
  logic [hvg_pkg::COORD_W-1:0]    s1_x;

  logic                           div_valid  [NS+1];
  logic                           div_inside [NS+1];
  logic [DW-1:0]                  hue_rem    [NS+1];
  logic [DW-1:0]                  val_rem    [NS+1];
  logic [hvg_pkg::HUE_Q_W-1:0]    hue_q      [NS+1];
  logic [hvg_pkg::HUE_Q_W-1:0]    val_q      [NS+1];
  logic [hvg_pkg::OFFSET_W-1:0]   offset_pipe [NS];
  logic [DW:0]                    hue_trial  [NS];
  logic [DW:0]                    val_trial  [NS];

  logic [hvg_pkg::OFFSET_W:0]     offset_sum;

  logic [hvg_pkg::HUE_Q_W-1:0]    hue;
  logic [hvg_pkg::COLOR_W-1:0]    val;
  logic [hvg_pkg::HUE_Q_W-1:0]    frac_wide;
  hvg_pkg::chan_sel_t             sel_r_next, sel_g_next, sel_b_next;

  logic                           sec_valid;
  logic                           sec_inside;
  logic [hvg_pkg::COLOR_W-1:0]    sec_v;
  logic [hvg_pkg::RAMP_W-1:0]     sec_prod;
  hvg_pkg::chan_sel_t             sec_sel_r, sec_sel_g, sec_sel_b;
  logic [hvg_pkg::OFFSET_W-1:0]   sec_offset;

  logic [hvg_pkg::RAMP_W+hvg_pkg::RECIP_W-1:0] scaled;
  logic [hvg_pkg::COLOR_W-1:0]    ramp;

  function automatic logic [hvg_pkg::COLOR_W-1:0] pick(
    input hvg_pkg::chan_sel_t          s,
    input logic [hvg_pkg::COLOR_W-1:0] full,
    input logic [hvg_pkg::COLOR_W-1:0] part
  );
    logic [hvg_pkg::COLOR_W-1:0] res;
    case (s)
      hvg_pkg::SEL_FULL: res = full;
      hvg_pkg::SEL_RAMP: res = part;
      default:           res = '0;
    endcase
    return res;
  endfunction

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= hvg_pkg::RST_FRAME_WIDTH;
      frame_height <= hvg_pkg::RST_FRAME_HEIGHT;
      line_pitch   <= hvg_pkg::RST_LINE_PITCH;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hvg_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data[hvg_pkg::DIM_W-1:0];
        hvg_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data[hvg_pkg::DIM_W-1:0];
        hvg_pkg::REG_LINE_PITCH:   line_pitch   <= cfg_data[hvg_pkg::PITCH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < NS; k++) begin
      hue_trial[k] = {1'b0, hue_rem[k]} - ((DW+1)'(frame_width) << (NS - 1 - k));
      val_trial[k] = {1'b0, val_rem[k]} - ((DW+1)'(frame_height) << (NS - 1 - k));
    end
  end

  assign offset_sum = {1'b0, s1_prod} + (hvg_pkg::OFFSET_W+1)'(s1_x);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= NS; k++) begin
        div_valid[k] <= 1'b0;
      end
    end else begin
      div_valid[0] <= accept;
      for (int k = 0; k < NS; k++) begin
        div_valid[k+1] <= div_valid[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    div_inside[0] <= (hvg_pkg::DIM_W'(pixel_x) < frame_width) &&
                     (hvg_pkg::DIM_W'(pixel_y) < frame_height);
    hue_rem[0]    <= DW'(pixel_x) * hvg_pkg::HUE_SCALE;
    val_rem[0]    <= DW'(pixel_y) * hvg_pkg::VAL_SCALE;
    hue_q[0]      <= '0;
    val_q[0]      <= '0;
    s1_prod       <= hvg_pkg::PROD_W'(pixel_y) * hvg_pkg::PROD_W'(line_pitch);
    s1_x          <= pixel_x;
    offset_pipe[0] <= hvg_pkg::OFFSET_W'({offset_sum, 2'b00});
    for (int k = 0; k < NS; k++) begin
      div_inside[k+1] <= div_inside[k];
      hue_rem[k+1]    <= hue_trial[k][DW] ? hue_rem[k] : hue_trial[k][DW-1:0];
      val_rem[k+1]    <= val_trial[k][DW] ? val_rem[k] : val_trial[k][DW-1:0];
      hue_q[k+1]      <= hue_q[k] | (hvg_pkg::HUE_Q_W'(!hue_trial[k][DW]) << (NS - 1 - k));
      val_q[k+1]      <= val_q[k] | (hvg_pkg::HUE_Q_W'(!val_trial[k][DW]) << (NS - 1 - k));
    end
    for (int k = 1; k < NS; k++) begin
      offset_pipe[k] <= offset_pipe[k-1];
    end
  end

  assign hue = hue_q[NS];
  assign val = hvg_pkg::VAL_MAX - val_q[NS][hvg_pkg::COLOR_W-1:0];

  always_comb begin
    frac_wide  = '0;
    sel_r_next = hvg_pkg::SEL_FULL;
    sel_g_next = hvg_pkg::SEL_ZERO;
    sel_b_next = hvg_pkg::SEL_ZERO;
    if (hue < hvg_pkg::HUE_60) begin
      frac_wide  = hue;
      sel_g_next = hvg_pkg::SEL_RAMP;
    end else if (hue < hvg_pkg::HUE_120) begin
      frac_wide  = hvg_pkg::HUE_120 - hue;
      sel_r_next = hvg_pkg::SEL_RAMP;
      sel_g_next = hvg_pkg::SEL_FULL;
    end else if (hue < hvg_pkg::HUE_180) begin
      frac_wide  = hue - hvg_pkg::HUE_120;
      sel_r_next = hvg_pkg::SEL_ZERO;
      sel_g_next = hvg_pkg::SEL_FULL;
      sel_b_next = hvg_pkg::SEL_RAMP;
    end else if (hue < hvg_pkg::HUE_240) begin
      frac_wide  = hvg_pkg::HUE_240 - hue;
      sel_r_next = hvg_pkg::SEL_ZERO;
      sel_g_next = hvg_pkg::SEL_RAMP;
      sel_b_next = hvg_pkg::SEL_FULL;
    end else if (hue < hvg_pkg::HUE_300) begin
      frac_wide  = hue - hvg_pkg::HUE_240;
      sel_r_next = hvg_pkg::SEL_RAMP;
      sel_b_next = hvg_pkg::SEL_FULL;
    end else if (hue < hvg_pkg::HUE_360) begin
      frac_wide  = hvg_pkg::HUE_360 - hue;
      sel_b_next = hvg_pkg::SEL_RAMP;
    end
    if (!div_inside[NS]) begin
      sel_r_next = hvg_pkg::SEL_ZERO;
      sel_g_next = hvg_pkg::SEL_ZERO;
      sel_b_next = hvg_pkg::SEL_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sec_valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      sec_valid <= div_valid[NS];
      done      <= sec_valid;
    end
  end

  always_ff @(posedge clk) begin
    sec_inside <= div_inside[NS];
    sec_v      <= val;
    sec_prod   <= hvg_pkg::RAMP_W'(val) * hvg_pkg::RAMP_W'(frac_wide[hvg_pkg::FRAC_W-1:0]);
    sec_sel_r  <= sel_r_next;
    sec_sel_g  <= sel_g_next;
    sec_sel_b  <= sel_b_next;
    sec_offset <= offset_pipe[NS-1];
  end

  assign scaled = (hvg_pkg::RAMP_W+hvg_pkg::RECIP_W)'(sec_prod) *
                  (hvg_pkg::RAMP_W+hvg_pkg::RECIP_W)'(hvg_pkg::RECIP_60);
  assign ramp   = scaled[hvg_pkg::RECIP_SHIFT +: hvg_pkg::COLOR_W];

  always_ff @(posedge clk) begin
    in_frame     <= sec_inside;
    pixel_offset <= sec_offset;
    red          <= pick(sec_sel_r, sec_v, ramp);
    green        <= pick(sec_sel_g, sec_v, ramp);
    blue         <= pick(sec_sel_b, sec_v, ramp);
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##(hvg_pkg::LATENCY) done)
    else $error("accepted pixel did not complete on time");

  a_reset_flush: assert property (@(posedge clk) rst |=> !done)
    else $error("done strobe right after reset");

  a_outside_black: assert property (@(posedge clk) disable iff (rst)
    done && !in_frame |-> red == '0 && green == '0 && blue == '0)
    else $error("out-of-frame pixel has color");

  a_one_dark_channel: assert property (@(posedge clk) disable iff (rst)
    done |-> red == '0 || green == '0 || blue == '0)
    else $error("full-saturation pixel without a zero channel");

endmodule
